// ===== hw/rtl/i2cms_pkg.sv =====
// types and constants shared by the i2c master command sequencer
package i2cms_pkg;

  typedef enum logic [3:0] {
    CMD_NONE  = 4'd0,
    CMD_START = 4'd1,
    CMD_STOP  = 4'd2,
    CMD_SEND  = 4'd3,
    CMD_READ  = 4'd4,
    CMD_WAIT  = 4'd5,
    CMD_ACK   = 4'd6,
    CMD_NACK  = 4'd7,
    CMD_CHECK = 4'd8
  } cmd_t;

  localparam logic [15:0] PHASE_RESET = 16'd336;

  // action counts per command
  localparam logic [4:0] STEPS_BYTE  = 5'd16;
  localparam logic [4:0] STEPS_ACK   = 5'd4;
  localparam logic [4:0] STEPS_CHECK = 5'd25;
  localparam logic [4:0] STEPS_SHORT = 5'd3;

  // where the parts of check device begin
  localparam logic [4:0] CHK_SEND = 5'd3;
  localparam logic [4:0] CHK_WAIT = 5'd19;
  localparam logic [4:0] CHK_STOP = 5'd22;

  typedef struct packed {
    logic [15:0] phase_counter;
    logic [4:0]  step_index;
    cmd_t        active_command;
    logic [7:0]  shift_out;
    logic [7:0]  shift_in;
    logic        ack_result;
    logic        fault_flag;
    logic        scl_drive;
    logic        sda_drive;
  } seq_state_t;

endpackage

// ===== hw/rtl/i2cms_step.sv =====
// next-state logic of the sequencer for one cycle word
module i2cms_step (
  input  i2cms_pkg::seq_state_t cur,
  input  logic [3:0]            req_type,
  input  logic [7:0]            tx_byte,
  input  logic                  sda_in,
  input  logic                  scl_in,
  input  logic [15:0]           phase_cycles,
  output i2cms_pkg::seq_state_t nxt,
  output logic                  done
);

  function automatic i2cms_pkg::seq_state_t act_start(i2cms_pkg::seq_state_t s,
                                                      logic [4:0] k);
    i2cms_pkg::seq_state_t r;
    r = s;
    if (k == 5'd0) begin
      r.sda_drive = 1'b1;
      r.scl_drive = 1'b1;
    end else if (k == 5'd1) begin
      r.sda_drive = 1'b0;
    end else if (k == 5'd2) begin
      r.scl_drive = 1'b0;
    end
    return r;
  endfunction

  function automatic i2cms_pkg::seq_state_t act_stop(i2cms_pkg::seq_state_t s,
                                                     logic [4:0] k);
    i2cms_pkg::seq_state_t r;
    r = s;
    if (k == 5'd0) begin
      r.sda_drive = 1'b0;
    end else if (k == 5'd1) begin
      r.scl_drive = 1'b1;
    end else if (k == 5'd2) begin
      r.sda_drive = 1'b1;
    end
    return r;
  endfunction

  function automatic i2cms_pkg::seq_state_t act_send(i2cms_pkg::seq_state_t s,
                                                     logic [4:0] k);
    i2cms_pkg::seq_state_t r;
    r = s;
    if (k >= i2cms_pkg::STEPS_BYTE) begin
      r.scl_drive = 1'b0;
      r.sda_drive = 1'b1;
    end else if (k[0]) begin
      r.scl_drive = 1'b1;
    end else begin
      if (k != 5'd0) r.scl_drive = 1'b0;
      // msb first: bit 7 - k/2
      r.sda_drive = s.shift_out[~k[3:1]];
    end
    return r;
  endfunction

  function automatic i2cms_pkg::seq_state_t act_read(i2cms_pkg::seq_state_t s,
                                                     logic [4:0] k, logic sda);
    i2cms_pkg::seq_state_t r;
    r = s;
    if (k < i2cms_pkg::STEPS_BYTE) begin
      if (!k[0]) begin
        r.scl_drive = 1'b1;
      end else begin
        r.shift_in  = {s.shift_in[6:0], sda};
        r.scl_drive = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic i2cms_pkg::seq_state_t act_wait(i2cms_pkg::seq_state_t s,
                                                     logic [4:0] k, logic sda);
    i2cms_pkg::seq_state_t r;
    r = s;
    if (k == 5'd0) begin
      r.sda_drive = 1'b1;
    end else if (k == 5'd1) begin
      r.scl_drive = 1'b1;
    end else if (k == 5'd2) begin
      r.ack_result = sda;
      r.scl_drive  = 1'b0;
    end
    return r;
  endfunction

  function automatic i2cms_pkg::seq_state_t act_pulse(i2cms_pkg::seq_state_t s,
                                                      logic [4:0] k, logic level);
    i2cms_pkg::seq_state_t r;
    r = s;
    if (k == 5'd0) begin
      r.sda_drive = level;
    end else if (k == 5'd1) begin
      r.scl_drive = 1'b1;
    end else if (k == 5'd2) begin
      r.scl_drive = 1'b0;
    end else if (k == 5'd3 && !level) begin
      r.sda_drive = 1'b1;
    end
    return r;
  endfunction

  function automatic i2cms_pkg::seq_state_t do_action(i2cms_pkg::seq_state_t s,
                                                      i2cms_pkg::cmd_t cmd,
                                                      logic [4:0] k, logic sda);
    i2cms_pkg::seq_state_t r;
    r = s;
    case (cmd)
      i2cms_pkg::CMD_START: r = act_start(s, k);
      i2cms_pkg::CMD_STOP:  r = act_stop(s, k);
      i2cms_pkg::CMD_SEND:  r = act_send(s, k);
      i2cms_pkg::CMD_READ:  r = act_read(s, k, sda);
      i2cms_pkg::CMD_WAIT:  r = act_wait(s, k, sda);
      i2cms_pkg::CMD_ACK:   r = act_pulse(s, k, 1'b0);
      i2cms_pkg::CMD_NACK:  r = act_pulse(s, k, 1'b1);
      i2cms_pkg::CMD_CHECK: begin
        if (k < i2cms_pkg::CHK_SEND) begin
          r = act_start(s, k);
        end else if (k < i2cms_pkg::CHK_WAIT) begin
          r = act_send(s, k - i2cms_pkg::CHK_SEND);
        end else if (k < i2cms_pkg::CHK_STOP) begin
          // closing of the address byte shares the first ack step
          if (k == i2cms_pkg::CHK_WAIT) r = act_send(s, i2cms_pkg::STEPS_BYTE);
          r = act_wait(r, k - i2cms_pkg::CHK_WAIT, sda);
        end else begin
          r = act_stop(s, k - i2cms_pkg::CHK_STOP);
        end
      end
      default: r = s;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] step_count(i2cms_pkg::cmd_t cmd);
    logic [4:0] n;
    case (cmd)
      i2cms_pkg::CMD_SEND:  n = i2cms_pkg::STEPS_BYTE;
      i2cms_pkg::CMD_READ:  n = i2cms_pkg::STEPS_BYTE;
      i2cms_pkg::CMD_ACK:   n = i2cms_pkg::STEPS_ACK;
      i2cms_pkg::CMD_CHECK: n = i2cms_pkg::STEPS_CHECK;
      default:              n = i2cms_pkg::STEPS_SHORT;
    endcase
    return n;
  endfunction

  logic [15:0] phase_len;
  logic [15:0] pc_dec;
  logic [4:0]  step_inc;
  logic        req_known;

  assign phase_len = (phase_cycles == 16'd0) ? 16'd1 : phase_cycles;
  assign pc_dec    = cur.phase_counter - 16'd1;
  assign step_inc  = cur.step_index + 5'd1;
  assign req_known = (req_type >= 4'(i2cms_pkg::CMD_START)) &&
                     (req_type <= 4'(i2cms_pkg::CMD_CHECK));

  always_comb begin
    nxt  = cur;
    done = 1'b0;
    if (cur.active_command == i2cms_pkg::CMD_NONE) begin
      if (req_type == 4'(i2cms_pkg::CMD_CHECK) && (!sda_in || !scl_in)) begin
        // bus not free: report at once, lines untouched
        nxt.fault_flag = 1'b1;
        nxt.ack_result = 1'b1;
        done           = 1'b1;
      end else if (req_known) begin
        if (req_type == 4'(i2cms_pkg::CMD_CHECK)) nxt.fault_flag = 1'b0;
        if (req_type == 4'(i2cms_pkg::CMD_READ))  nxt.shift_in = 8'd0;
        nxt.shift_out      = tx_byte;
        nxt.active_command = i2cms_pkg::cmd_t'(req_type);
        nxt.step_index     = 5'd0;
        nxt                = do_action(nxt, i2cms_pkg::cmd_t'(req_type), 5'd0, sda_in);
        nxt.phase_counter  = phase_len;
      end
    end else begin
      nxt.phase_counter = pc_dec;
      if (pc_dec == 16'd0) begin
        nxt.step_index = step_inc;
        nxt            = do_action(nxt, cur.active_command, step_inc, sda_in);
        if (step_inc >= step_count(cur.active_command)) begin
          nxt.active_command = i2cms_pkg::CMD_NONE;
          nxt.step_index     = 5'd0;
          done               = 1'b1;
        end else begin
          nxt.phase_counter = phase_len;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/i2c_master_command_sequencer.sv =====
// top level of the i2c master command sequencer
//
// every input word is one tick of the bus sequencer: it carries the sampled
// scl/sda levels and, while the sequencer is idle, an optional command
// (start, stop, send, read, wait ack, ack, nack, check device). each word
// gives exactly one output word with the line drives, busy, a one-word done
// pulse, the read byte, the ack bit and the bus fault flag.
// a word is taken into an input register, then the sequencer logic updates
// its state and fills the output register. one word per cycle is sustained
// while out_ready stays high, set by the single sequencer update per word.
// when the receiver stalls, the output register holds its word and the input
// register takes one more word; then in_ready drops until the output moves.
// reset empties both registers, releases both lines, goes idle with ack 1,
// and sets the phase length to 336. cfg_data (phase length) is always ready
// and is meant to be written while no word is in flight.
module i2c_master_command_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  req_type,
  input  logic [7:0]  tx_byte,
  input  logic        sda_in,
  input  logic        scl_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_out,
  output logic        sda_out,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  rx_byte,
  output logic        ack_bit,
  output logic        bus_fault,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] phase_cycles;

  logic       s1_valid;
  logic [3:0] s1_req;
  logic [7:0] s1_tx;
  logic       s1_sda;
  logic       s1_scl;

  i2cms_pkg::seq_state_t st;
  i2cms_pkg::seq_state_t st_next;
  logic                  done_next;
  logic                  out_load;

  assign cfg_ready = 1'b1;
  assign out_load  = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_cycles <= i2cms_pkg::PHASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      phase_cycles <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req <= req_type;
      s1_tx  <= tx_byte;
      s1_sda <= sda_in;
      s1_scl <= scl_in;
    end
  end

  i2cms_step u_step (
    .cur          (st),
    .req_type     (s1_req),
    .tx_byte      (s1_tx),
    .sda_in       (s1_sda),
    .scl_in       (s1_scl),
    .phase_cycles (phase_cycles),
    .nxt          (st_next),
    .done         (done_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase_counter  <= 16'd0;
      st.step_index     <= 5'd0;
      st.active_command <= i2cms_pkg::CMD_NONE;
      st.shift_out      <= 8'd0;
      st.shift_in       <= 8'd0;
      st.ack_result     <= 1'b1;
      st.fault_flag     <= 1'b0;
      st.scl_drive      <= 1'b1;
      st.sda_drive      <= 1'b1;
    end else if (out_load) begin
      st <= st_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      scl_out   <= st_next.scl_drive;
      sda_out   <= st_next.sda_drive;
      busy_res  <= (st_next.active_command != i2cms_pkg::CMD_NONE);
      done_res  <= done_next;
      rx_byte   <= st_next.shift_in;
      ack_bit   <= st_next.ack_result;
      bus_fault <= st_next.fault_flag;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  a_idle_step_zero: assert property (@(posedge clk) disable iff (rst)
    st.active_command == i2cms_pkg::CMD_NONE |-> st.step_index == 5'd0)
    else $error("step index left non-zero when idle");

  a_busy_counter: assert property (@(posedge clk) disable iff (rst)
    st.active_command != i2cms_pkg::CMD_NONE |-> st.phase_counter != 16'd0)
    else $error("phase counter empty while a command runs");

endmodule
